// ----- design/psched_pkg.sv -----
// Shared definitions for the process admission scheduler.
// Holds event and request codes, register indexes, FSM state type and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package psched_pkg;

  localparam int RUN_DEPTH_DEF  = 16;
  localparam int WAIT_DEPTH_DEF = 16;

  // At most this many waiting jobs are started by one kill.
  localparam int MAX_STARTS = 16;
  localparam int STARTS_W   = $clog2(MAX_STARTS + 1);

  localparam int ID_W     = 16;
  localparam int SIZE_W   = 16;
  localparam int ENTRY_W  = ID_W + SIZE_W;
  localparam int SLOT_W   = 5;
  localparam int CAP_W    = 16;
  localparam int COUNT_W  = 5;
  localparam int RES_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST = 5'd4;
  localparam logic [CAP_W-1:0]  MEM_CAP_RST    = 16'd1024;

  localparam logic KIND_CREATE = 1'b0;
  localparam logic KIND_KILL   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LIMIT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MEM_CAP    = 1'b1;

  localparam logic [RES_W-1:0] EV_STARTED      = 3'd0;
  localparam logic [RES_W-1:0] EV_QUEUED       = 3'd1;
  localparam logic [RES_W-1:0] EV_KILLED       = 3'd2;
  localparam logic [RES_W-1:0] EV_STARTED_WAIT = 3'd3;
  localparam logic [RES_W-1:0] EV_KILL_NONE    = 3'd4;
  localparam logic [RES_W-1:0] EV_REJECTED     = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CHECK,
    ST_GAP
  } state_e;

  typedef struct packed {
    logic latch_in;      // capture the accepted request
    logic create;        // resolve a create and write its single beat
    logic kill_empty;    // write the beat for a kill with nothing running
    logic kill;          // retire the oldest running job into the pending beat
    logic emit_pending;  // move the pending beat to the output register
    logic start;         // start the job at the waiting head
  } cmd_t;

  typedef struct packed {
    logic kind_kill;
    logic run_empty;
    logic can_start;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- design/psched_ctrl.sv -----
// Controller state machine of the process admission scheduler.
// Sequences accept, decision, and the start loop; uses psched_pkg.
`default_nettype none

module psched_ctrl
  import psched_pkg::*;
(
  input  wire   clk_i,
  input  wire   rst_ni,
  input  wire   in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (stat_i.kind_kill && !stat_i.run_empty) begin
          state_d = ST_CHECK;
        end else if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (stat_i.out_free) begin
          state_d = stat_i.can_start ? ST_GAP : ST_IDLE;
        end
      end
      // The waiting store read is registered, so a new head is read here before it is checked.
      ST_GAP: state_d = ST_CHECK;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      ST_DECIDE: begin
        if (stat_i.kind_kill) begin
          if (!stat_i.run_empty) begin
            cmd_o.kill = 1'b1;
          end else begin
            cmd_o.kill_empty = stat_i.out_free;
          end
        end else begin
          cmd_o.create = stat_i.out_free;
        end
      end
      ST_CHECK: begin
        cmd_o.emit_pending = stat_i.out_free;
        cmd_o.start        = stat_i.out_free && stat_i.can_start;
      end
      ST_GAP: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/psched_dp.sv -----
// Datapath of the process admission scheduler: run and wait stores,
// FIFO pointers, memory accounting and the output register. Uses psched_pkg.
`default_nettype none

module psched_dp
  import psched_pkg::*;
#(
  parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   cfg_we_i,
  input  wire [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire                   in_kind_i,
  input  wire [ID_W-1:0]        in_id_i,
  input  wire [SIZE_W-1:0]      in_size_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic [RES_W-1:0]      out_res_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic [SIZE_W-1:0]     out_size_o,
  output logic [CAP_W-1:0]      out_free_o,
  output logic [COUNT_W-1:0]    out_count_o,
  output logic                  out_last_o
);

  localparam int RAW  = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
  localparam int RFW  = $clog2(RUN_DEPTH + 1);
  localparam int WAW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;
  localparam int WFW  = $clog2(WAIT_DEPTH + 1);
  localparam int UW   = SIZE_W + RFW;
  localparam int CMPW = (RFW > SLOT_W) ? RFW : SLOT_W;

  logic [ENTRY_W-1:0] run_mem  [RUN_DEPTH];
  logic [ENTRY_W-1:0] wait_mem [WAIT_DEPTH];
  logic [ENTRY_W-1:0] run_rd_q, wait_rd_q;

  logic [SLOT_W-1:0] slot_limit_q;
  logic [CAP_W-1:0]  free_q;
  logic [UW-1:0]     used_q;
  logic [RAW-1:0]    run_head_q, run_tail_q;
  logic [RFW-1:0]    run_fill_q;
  logic [WAW-1:0]    wait_head_q, wait_tail_q;
  logic [WFW-1:0]    wait_fill_q;
  logic [STARTS_W-1:0] starts_q;
  logic              out_valid_q;

  logic              kind_q;
  logic [ID_W-1:0]   id_q;
  logic [SIZE_W-1:0] size_q;

  logic [RES_W-1:0]   pend_res_q;
  logic [ENTRY_W-1:0] pend_entry_q;
  logic [CAP_W-1:0]   pend_free_q;
  logic [RFW-1:0]     pend_fill_q;

  logic [RES_W-1:0]  out_res_q;
  logic [ID_W-1:0]   out_id_q;
  logic [SIZE_W-1:0] out_size_q;
  logic [CAP_W-1:0]  out_free_q;
  logic [RFW-1:0]    out_fill_q;
  logic              out_last_q;

  logic [RAW-1:0]     run_head_inc, run_tail_inc;
  logic [WAW-1:0]     wait_head_inc, wait_tail_inc;
  logic               run_slot, fits, wait_full, can_start, emit_any;
  logic [SIZE_W:0]    kill_sum;
  logic [CAP_W-1:0]   kill_free;
  logic [SIZE_W-1:0]  run_size, wait_size;
  logic [CAP_W-1:0]   cap_free;
  logic [UW-1:0]      cap_ext;
  logic [ENTRY_W-1:0] in_entry;

  assign run_head_inc  = (run_head_q == RAW'(RUN_DEPTH - 1)) ? '0 : run_head_q + RAW'(1);
  assign run_tail_inc  = (run_tail_q == RAW'(RUN_DEPTH - 1)) ? '0 : run_tail_q + RAW'(1);
  assign wait_head_inc = (wait_head_q == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_head_q + WAW'(1);
  assign wait_tail_inc = (wait_tail_q == WAW'(WAIT_DEPTH - 1)) ? '0 : wait_tail_q + WAW'(1);

  assign run_size  = run_rd_q[ENTRY_W-1:ID_W];
  assign wait_size = wait_rd_q[ENTRY_W-1:ID_W];
  assign in_entry  = {size_q, id_q};

  // The usable slot count is the smaller of the register and the store depth.
  assign run_slot  = (CMPW'(run_fill_q) < CMPW'(slot_limit_q)) &&
                     (run_fill_q != RFW'(RUN_DEPTH));
  assign fits      = (size_q <= free_q) && run_slot;
  assign wait_full = (wait_fill_q == WFW'(WAIT_DEPTH));

  assign kill_sum  = {1'b0, free_q} + {1'b0, run_size};
  assign kill_free = kill_sum[SIZE_W] ? '1 : kill_sum[SIZE_W-1:0];

  assign can_start = (wait_fill_q != '0) && (wait_size <= free_q) && run_slot &&
                     (starts_q != STARTS_W'(MAX_STARTS));

  // Free memory after a capacity write is the capacity less what the running
  // jobs hold, floored at zero.
  assign cap_ext  = UW'(cfg_wdata_i);
  assign cap_free = (used_q >= cap_ext) ? '0 : CAP_W'(cap_ext - used_q);

  assign emit_any = cmd_i.create || cmd_i.kill_empty || cmd_i.emit_pending;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_limit_q <= SLOT_LIMIT_RST;
      free_q       <= MEM_CAP_RST;
      used_q       <= '0;
      run_head_q   <= '0;
      run_tail_q   <= '0;
      run_fill_q   <= '0;
      wait_head_q  <= '0;
      wait_tail_q  <= '0;
      wait_fill_q  <= '0;
      starts_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (emit_any) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        if (cfg_index_i == CFG_SLOT_LIMIT) begin
          slot_limit_q <= cfg_wdata_i[SLOT_W-1:0];
        end else begin
          free_q <= cap_free;
        end
      end else if (cmd_i.create) begin
        if (fits) begin
          free_q     <= free_q - size_q;
          used_q     <= used_q + UW'(size_q);
          run_tail_q <= run_tail_inc;
          run_fill_q <= run_fill_q + RFW'(1);
        end else if (!wait_full) begin
          wait_tail_q <= wait_tail_inc;
          wait_fill_q <= wait_fill_q + WFW'(1);
        end
      end else if (cmd_i.kill) begin
        free_q     <= kill_free;
        used_q     <= used_q - UW'(run_size);
        run_head_q <= run_head_inc;
        run_fill_q <= run_fill_q - RFW'(1);
        starts_q   <= '0;
      end else if (cmd_i.start) begin
        free_q      <= free_q - wait_size;
        used_q      <= used_q + UW'(wait_size);
        wait_head_q <= wait_head_inc;
        wait_fill_q <= wait_fill_q - WFW'(1);
        run_tail_q  <= run_tail_inc;
        run_fill_q  <= run_fill_q + RFW'(1);
        starts_q    <= starts_q + STARTS_W'(1);
      end
    end
  end

  // Both stores are read continuously at their heads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.create && fits) begin
      run_mem[run_tail_q] <= in_entry;
    end else if (cmd_i.start) begin
      run_mem[run_tail_q] <= wait_rd_q;
    end
    run_rd_q <= run_mem[run_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.create && !fits && !wait_full) begin
      wait_mem[wait_tail_q] <= in_entry;
    end
    wait_rd_q <= wait_mem[wait_head_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      kind_q <= in_kind_i;
      id_q   <= in_id_i;
      size_q <= in_size_i;
    end

    // A kill or start beat is held back until it is known whether another
    // start follows, which decides its last flag.
    if (cmd_i.kill) begin
      pend_res_q   <= EV_KILLED;
      pend_entry_q <= run_rd_q;
      pend_free_q  <= kill_free;
      pend_fill_q  <= run_fill_q - RFW'(1);
    end else if (cmd_i.start) begin
      pend_res_q   <= EV_STARTED_WAIT;
      pend_entry_q <= wait_rd_q;
      pend_free_q  <= free_q - wait_size;
      pend_fill_q  <= run_fill_q + RFW'(1);
    end

    if (cmd_i.create) begin
      out_id_q   <= id_q;
      out_size_q <= size_q;
      out_last_q <= 1'b1;
      if (fits) begin
        out_res_q  <= EV_STARTED;
        out_free_q <= free_q - size_q;
        out_fill_q <= run_fill_q + RFW'(1);
      end else begin
        out_res_q  <= wait_full ? EV_REJECTED : EV_QUEUED;
        out_free_q <= free_q;
        out_fill_q <= run_fill_q;
      end
    end else if (cmd_i.kill_empty) begin
      out_res_q  <= EV_KILL_NONE;
      out_id_q   <= '0;
      out_size_q <= '0;
      out_free_q <= free_q;
      out_fill_q <= run_fill_q;
      out_last_q <= 1'b1;
    end else if (cmd_i.emit_pending) begin
      out_res_q  <= pend_res_q;
      out_id_q   <= pend_entry_q[ID_W-1:0];
      out_size_q <= pend_entry_q[ENTRY_W-1:ID_W];
      out_free_q <= pend_free_q;
      out_fill_q <= pend_fill_q;
      out_last_q <= !can_start;
    end
  end

  always_comb begin
    stat_o.kind_kill = (kind_q == KIND_KILL);
    stat_o.run_empty = (run_fill_q == '0);
    stat_o.can_start = can_start;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign out_id_o    = out_id_q;
  assign out_size_o  = out_size_q;
  assign out_free_o  = out_free_q;
  assign out_count_o = COUNT_W'(out_fill_q);
  assign out_last_o  = out_last_q;

endmodule

`default_nettype wire

// ----- design/process_admission_scheduler_core.sv -----
// Process admission scheduler: create requests start, queue or reject jobs
// against a slot limit and a memory pool; a kill retires the oldest running
// job and then starts waiting jobs in order from the head of the waiting
// queue. One request is handled at a time. A create, or a kill with nothing
// running, is resolved in the decide state and written as its single beat
// once the output register is free. After each start of a waiting job a kill
// passes through a gap state, as the waiting store's registered read port must
// refresh before the next head is checked. The next request is accepted while
// the last result beat still waits in the output register. No clearing pass is
// needed after reset. Depends on psched_pkg, psched_ctrl and psched_dp.
`default_nettype none

module process_admission_scheduler_core
  import psched_pkg::*;
#(
  parameter int RUN_DEPTH  = RUN_DEPTH_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire                  s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // tdata: job_id[15:0], job_size[31:16]
  input  wire [31:0]           s_axis_tdata_i,
  // tuser: kind[0]
  input  wire                  s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  wire                  m_axis_tready_i,
  // tdata: event_id[15:0], event_size[31:16], free_memory[47:32],
  // running_count[52:48], zero fill[55:53]
  output logic [55:0]          m_axis_tdata_o,
  // tuser: event_res[2:0]
  output logic [RES_W-1:0]     m_axis_tuser_o,
  output logic                 m_axis_tlast_o
);

  cmd_t  cmd;
  stat_t stat;

  logic [ID_W-1:0]    ev_id;
  logic [SIZE_W-1:0]  ev_size;
  logic [CAP_W-1:0]   ev_free;
  logic [COUNT_W-1:0] ev_count;

  psched_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  psched_dp #(
    .RUN_DEPTH  (RUN_DEPTH),
    .WAIT_DEPTH (WAIT_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_kind_i   (s_axis_tuser_i),
    .in_id_i     (s_axis_tdata_i[15:0]),
    .in_size_i   (s_axis_tdata_i[31:16]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_res_o   (m_axis_tuser_o),
    .out_id_o    (ev_id),
    .out_size_o  (ev_size),
    .out_free_o  (ev_free),
    .out_count_o (ev_count),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {3'b000, ev_count, ev_free, ev_size, ev_id};

`ifndef NO_ASSERTIONS
  // One request at a time: after an accept the input side closes.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while a request is in progress");

  // A start always goes together with moving the previous beat out.
  a_start_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> (cmd.emit_pending && stat.out_free))
    else $error("waiting job started without emitting the pending beat");

  // A beat is never written over while it is still waiting downstream.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |-> !(cmd.create || cmd.kill_empty ||
      cmd.emit_pending))
    else $error("output beat overwritten while stalled");
`endif

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for process_admission_scheduler_core: a directed table, then
// random create/kill traffic under several slot and memory settings, with random stalls
// in every phase but the last. Depends on psched_pkg and the scheduler RTL.
`default_nettype none

module tb_top;
  import psched_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 24;

  typedef struct packed {
    logic [RES_W-1:0]   res;
    logic [ID_W-1:0]    id;
    logic [SIZE_W-1:0]  size;
    logic [CAP_W-1:0]   free;
    logic [COUNT_W-1:0] count;
    logic               last;
  } sched_event_t;

  typedef enum logic {ROW_REQ, ROW_CFG} row_op_e;

  typedef struct {
    row_op_e      op;
    logic         kind;   // register index on a register row
    logic [15:0]  id;     // register value on a register row
    logic [15:0]  size;
    int           reps;
    bit           typed;
    sched_event_t ev;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [31:0]           s_axis_tdata_i = '0;
  logic                  s_axis_tuser_i = 1'b0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [55:0]           m_axis_tdata_o;
  logic [RES_W-1:0]      m_axis_tuser_o;
  logic                  m_axis_tlast_o;

  process_admission_scheduler_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Shadow of the scheduler state, entries are {size, id}.
  logic [ENTRY_W-1:0] running_jobs[$];
  logic [ENTRY_W-1:0] waiting_jobs[$];
  int                 free_mem  = int'(MEM_CAP_RST);
  int                 slot_cfg  = int'(SLOT_LIMIT_RST);
  int                 cap_cfg   = int'(MEM_CAP_RST);

  sched_event_t pending_events[$];
  sched_event_t typed_ev;
  bit           typed_on  = 1'b0;
  bit           idle_en   = 1'b1;
  bit           hold_req  = 1'b0;
  int           fail_count = 0;
  int           cycle_count = 0;
  row_t         rows[$];

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic sched_event_t pack_event(logic [RES_W-1:0] res, logic [ENTRY_W-1:0] entry,
                                              int free, int count, logic last);
    sched_event_t e;
    e.res   = res;
    e.id    = entry[15:0];
    e.size  = entry[31:16];
    e.free  = free[15:0];
    e.count = count[COUNT_W-1:0];
    e.last  = last;
    return e;
  endfunction

  function automatic int slot_limit_eff();
    return (slot_cfg < RUN_DEPTH_DEF) ? slot_cfg : RUN_DEPTH_DEF;
  endfunction

  task automatic admit_request(input logic kind, input logic [15:0] id, input logic [15:0] size,
                               output sched_event_t evs[$]);
    logic [ENTRY_W-1:0] entry;
    logic [ENTRY_W-1:0] head;
    sched_event_t       e;
    int                 starts;
    evs.delete();
    entry = {size, id};
    if (kind == KIND_CREATE) begin
      if (int'(size) <= free_mem && running_jobs.size() < slot_limit_eff()) begin
        free_mem -= int'(size);
        running_jobs.push_back(entry);
        evs.push_back(pack_event(EV_STARTED, entry, free_mem, running_jobs.size(), 1'b0));
      end else if (waiting_jobs.size() < WAIT_DEPTH_DEF) begin
        waiting_jobs.push_back(entry);
        evs.push_back(pack_event(EV_QUEUED, entry, free_mem, running_jobs.size(), 1'b0));
      end else begin
        evs.push_back(pack_event(EV_REJECTED, entry, free_mem, running_jobs.size(), 1'b0));
      end
    end else if (running_jobs.size() == 0) begin
      evs.push_back(pack_event(EV_KILL_NONE, '0, free_mem, 0, 1'b0));
    end else begin
      head = running_jobs.pop_front();
      free_mem += int'(head[31:16]);
      if (free_mem > 65535) free_mem = 65535;
      evs.push_back(pack_event(EV_KILLED, head, free_mem, running_jobs.size(), 1'b0));
      // Start from the waiting head until it does not fit; the head blocks the rest.
      starts = 0;
      while (waiting_jobs.size() > 0 && starts < MAX_STARTS) begin
        head = waiting_jobs[0];
        if (int'(head[31:16]) > free_mem || running_jobs.size() >= slot_limit_eff()) break;
        free_mem -= int'(head[31:16]);
        void'(waiting_jobs.pop_front());
        running_jobs.push_back(head);
        evs.push_back(pack_event(EV_STARTED_WAIT, head, free_mem, running_jobs.size(), 1'b0));
        starts++;
      end
    end
    e = evs.pop_back();
    e.last = 1'b1;
    evs.push_back(e);
  endtask

  // Accepted requests feed the predictor; accepted result beats are checked in order.
  always @(posedge clk_i) begin : monitor
    sched_event_t evs[$];
    sched_event_t e;
    logic [55:0]  exp_data;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        admit_request(s_axis_tuser_i, s_axis_tdata_i[15:0], s_axis_tdata_i[31:16], evs);
        if (typed_on) begin
          pending_events.push_back(typed_ev);
        end else begin
          foreach (evs[i]) pending_events.push_back(evs[i]);
        end
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (pending_events.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected beat res=%0d data=%h last=%b",
                     m_axis_tuser_o, m_axis_tdata_o, m_axis_tlast_o);
        end else begin
          e = pending_events.pop_front();
          exp_data = {3'b000, e.count, e.free, e.size, e.id};
          if (m_axis_tdata_o !== exp_data || m_axis_tuser_o !== e.res ||
              m_axis_tlast_o !== e.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: beat mismatch exp res=%0d id=%h size=%h free=%h cnt=%0d ",
                        "last=%b got res=%0d id=%h size=%h free=%h cnt=%0d last=%b fill=%b"},
                       e.res, e.id, e.size, e.free, e.count, e.last,
                       m_axis_tuser_o, m_axis_tdata_o[15:0], m_axis_tdata_o[31:16],
                       m_axis_tdata_o[47:32], m_axis_tdata_o[52:48], m_axis_tlast_o,
                       m_axis_tdata_o[55:53]);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    int stall_left;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready_i = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready_i = 1'b0;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 5) - 1;
        m_axis_tready_i = 1'b0;
      end else begin
        m_axis_tready_i = 1'b1;
      end
    end
  end

  // Called and returns at a falling edge; valid stays high between back-to-back beats.
  task automatic send_request(input logic kind, input logic [15:0] id, input logic [15:0] size);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tvalid_i = 1'b1;
    s_axis_tdata_i  = {size, id};
    s_axis_tuser_i  = kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // Registers change only once every outstanding result has been drained.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    int used;
    s_axis_tvalid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CFG_SLOT_LIMIT) begin
      slot_cfg = int'(value[SLOT_W-1:0]);
    end else begin
      cap_cfg = int'(value);
      used = 0;
      foreach (running_jobs[i]) used += int'(running_jobs[i][31:16]);
      free_mem = (used >= cap_cfg) ? 0 : cap_cfg - used;
    end
  endtask

  task automatic add_row(row_op_e op, logic kind, logic [15:0] id, logic [15:0] size, int reps,
                         bit typed, logic [RES_W-1:0] res, logic [15:0] ev_id,
                         logic [15:0] ev_size, int free, int count);
    row_t r;
    r.op    = op;
    r.kind  = kind;
    r.id    = id;
    r.size  = size;
    r.reps  = reps;
    r.typed = typed;
    r.ev    = pack_event(res, {ev_size, ev_id}, free, count, 1'b1);
    rows.push_back(r);
  endtask

  initial begin : stimulus
    logic        kind;
    logic [15:0] id;
    logic [15:0] size;
    logic [15:0] slot_val;
    logic [15:0] cap_val;
    int          pick;

    // Directed table, starting from the reset settings (4 slots, 1024 units).
    add_row(ROW_REQ, KIND_KILL,   16'h1234, 16'h5678, 1, 1, EV_KILL_NONE, 0, 0, 1024, 0);
    add_row(ROW_REQ, KIND_CREATE, 16'hFFFF, 16'h0000, 1, 1, EV_STARTED, 16'hFFFF, 0, 1024, 1);
    add_row(ROW_REQ, KIND_CREATE, 16'h0000, 16'hFFFF, 1, 1, EV_QUEUED, 0, 16'hFFFF, 1024, 1);
    add_row(ROW_REQ, KIND_CREATE, 16'h0001, 16'd1024, 1, 1, EV_STARTED, 1, 16'd1024, 0, 2);
    add_row(ROW_REQ, KIND_CREATE, 16'h0002, 16'h0001, 1, 1, EV_QUEUED, 2, 1, 0, 2);
    // The large job at the waiting head blocks the small one behind it.
    add_row(ROW_REQ, KIND_KILL,   16'hFFFF, 16'hFFFF, 1, 1, EV_KILLED, 16'hFFFF, 0, 0, 1);
    add_row(ROW_REQ, KIND_KILL,   16'h0000, 16'h0000, 1, 1, EV_KILLED, 1, 16'd1024, 1024, 0);
    add_row(ROW_CFG, CFG_MEM_CAP, 16'hFFFF, 0, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_REQ, KIND_KILL,   16'h4321, 16'h8765, 1, 1, EV_KILL_NONE, 0, 0, 65535, 0);
    // A create that fits starts at once even while others wait.
    add_row(ROW_REQ, KIND_CREATE, 16'h0003, 16'd10, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_REQ, KIND_KILL,   16'h0000, 16'h0000, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_CFG, CFG_SLOT_LIMIT, 16'h0000, 0, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_REQ, KIND_CREATE, 16'h0100, 16'h0001, 15, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_REQ, KIND_CREATE, 16'hAAAA, 16'h5555, 1, 1, EV_REJECTED, 16'hAAAA, 16'h5555, 0, 1);
    add_row(ROW_CFG, CFG_SLOT_LIMIT, 16'hFFFF, 0, 1, 0, EV_STARTED, 0, 0, 0, 0);
    // This kill fills all sixteen slots from the waiting queue.
    add_row(ROW_REQ, KIND_KILL,   16'h0000, 16'h0000, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_CFG, CFG_MEM_CAP, 16'h0001, 0, 1, 0, EV_STARTED, 0, 0, 0, 0);
    add_row(ROW_REQ, KIND_KILL,   16'h0000, 16'h0000, 1, 0, EV_STARTED, 0, 0, 0, 0);

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (rows[r]) begin
      if (rows[r].op == ROW_CFG) begin
        write_register(rows[r].kind, rows[r].id);
      end else begin
        for (int k = 0; k < rows[r].reps; k++) begin
          typed_on = rows[r].typed;
          typed_ev = rows[r].ev;
          send_request(rows[r].kind, rows[r].id + k[15:0], rows[r].size);
        end
      end
    end
    typed_on = 1'b0;

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin slot_val = 16'd1;  cap_val = 16'hFFFF; end
        1: begin slot_val = 16'd16; cap_val = 16'd1; end
        2: begin
          slot_val = 16'($urandom_range(2, 8));
          cap_val  = 16'($urandom_range(100, 3000));
        end
        3: begin slot_val = 16'($urandom); cap_val = 16'($urandom_range(1, 65535)); end
        4: begin slot_val = 16'd4;  cap_val = 16'd1024; end
        default: begin
          slot_val = 16'($urandom_range(1, 16));
          cap_val  = 16'($urandom_range(200, 5000));
        end
      endcase
      write_register(CFG_SLOT_LIMIT, slot_val);
      write_register(CFG_MEM_CAP, cap_val);
      idle_en = (phase != PHASES - 1);
      if (phase == 2) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = ($urandom_range(0, 9) < 4) ? KIND_KILL : KIND_CREATE;
        id   = 16'($urandom);
        pick = $urandom_range(0, 19);
        if (pick < 12)      size = 16'($urandom_range(0, (cap_cfg / 3 > 0) ? cap_cfg / 3 : 1));
        else if (pick < 15) size = 16'h0000;
        else if (pick < 18) size = 16'($urandom);
        else                size = free_mem[15:0];
        send_request(kind, id, size);
      end
    end

    s_axis_tvalid_i = 1'b0;
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
